FILE: hdl/las_pkg.sv
// Shared types and constants of the LED animation sequencer.
// Used by las_ctrl, las_dp, led_animation_sequencer_unit and the verification files; depends on nothing.
package las_pkg;

   // Table size and derived widths.
   localparam int MaxSteps = 16;
   localparam int IdxW     = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
   localparam int CntW     = $clog2(MaxSteps + 1);

   // Field widths of the channels.
   localparam int CmdW      = 2;
   localparam int EntryIdxW = 4;
   localparam int AnimW     = 2;
   localparam int RateW     = 2;
   localparam int TargetW   = 3;
   localparam int DurW      = 16;
   localparam int PwmW      = 8;
   localparam int LedW      = 3;
   localparam int StepCntW  = 5;
   localparam int CsrIdxW   = 1;
   localparam int CsrDataW  = 5;

   // Level is 8.2 unsigned fixed point, counted in quarters.
   localparam int            LevelW    = 10;
   localparam logic [9:0]    LevelFull = 10'd1020;

   // Command codes.
   localparam logic [CmdW-1:0] CmdTick  = 2'd0;
   localparam logic [CmdW-1:0] CmdWrite = 2'd1;
   localparam logic [CmdW-1:0] CmdStart = 2'd2;

   // Animation codes.
   localparam logic [AnimW-1:0] AnimOn      = 2'd0;
   localparam logic [AnimW-1:0] AnimOff     = 2'd1;
   localparam logic [AnimW-1:0] AnimFadeIn  = 2'd2;
   localparam logic [AnimW-1:0] AnimFadeOut = 2'd3;

   // Target code that matches every LED.
   localparam logic [TargetW-1:0] TargetAny = 3'd5;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrLedIdentity = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrStepCount   = 1'd1;

   // One input beat.
   typedef struct packed {
      logic [CmdW-1:0]      cmd;
      logic [EntryIdxW-1:0] entry_index;
      logic [AnimW-1:0]     entry_animation;
      logic [RateW-1:0]     entry_rate;
      logic [TargetW-1:0]   entry_target;
      logic                 entry_once;
      logic [DurW-1:0]      entry_duration;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [PwmW-1:0]      pwm_level;
      logic                 pwm_update;
      logic [EntryIdxW-1:0] entry_position;
      logic [AnimW-1:0]     animation_now;
   } rsp_type;

   // One step table entry.
   typedef struct packed {
      logic [DurW-1:0]    duration;
      logic               once;
      logic [TargetW-1:0] target;
      logic [RateW-1:0]   rate;
      logic [AnimW-1:0]   animation;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   // Source of the table read address.
   typedef enum logic [1:0] {
      ADDR_POS  = 2'd0,
      ADDR_ZERO = 2'd1,
      ADDR_CAND = 2'd2
   } addr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch_req;
      logic         ram_we;
      addr_sel_type addr_sel;
      logic         do_start;
      logic         load_entry;
      logic         apply_tick;
      logic         tick_dec;
      logic         adv_empty;
      logic         scan_init;
      logic         scan_norm;
      logic         scan_next;
      logic         scan_done;
      logic         respond;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CmdW-1:0] cmd;
      logic            started;
      logic            ticks_le1;
      logic            count_zero;
      logic            cand_ge_n;
      logic            scan_stop;
   } dp_stat_type;

endpackage

FILE: hdl/las_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module las_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
   input  logic [Width-1:0]                       wdata,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
   output logic [Width-1:0]                       rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/las_ctrl.sv
// Controller state machine of the LED animation sequencer.
// Depends on las_pkg for the command and status structs and the codes.
module las_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  las_pkg::dp_stat_type stat,
   output las_pkg::dp_cmd_type  ctl
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_LOAD   = 8'b0000_0100,
      S_TAPPLY = 8'b0000_1000,
      S_NORM   = 8'b0001_0000,
      S_SRD    = 8'b0010_0000,
      S_SCHK   = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      ctl.addr_sel = las_pkg::ADDR_POS;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               las_pkg::CmdWrite: begin
                  ctl.ram_we = 1'b1;
                  state_in   = S_RESP;
               end
               las_pkg::CmdStart: begin
                  ctl.do_start = 1'b1;
                  ctl.addr_sel = las_pkg::ADDR_ZERO;
                  state_in     = S_LOAD;
               end
               las_pkg::CmdTick: begin
                  if (stat.started) begin
                     ctl.addr_sel = las_pkg::ADDR_POS;
                     state_in     = S_TAPPLY;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_LOAD: begin
            ctl.load_entry = 1'b1;
            state_in       = S_RESP;
         end
         S_TAPPLY: begin
            ctl.apply_tick = 1'b1;
            if (!stat.ticks_le1) begin
               ctl.tick_dec = 1'b1;
               state_in     = S_RESP;
            end else if (stat.count_zero) begin
               ctl.adv_empty = 1'b1;
               state_in      = S_RESP;
            end else begin
               ctl.scan_init = 1'b1;
               state_in      = S_NORM;
            end
         end
         S_NORM: begin
            if (stat.cand_ge_n) begin
               ctl.scan_norm = 1'b1;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            ctl.addr_sel = las_pkg::ADDR_CAND;
            state_in     = S_SCHK;
         end
         S_SCHK: begin
            if (stat.scan_stop) begin
               ctl.scan_done = 1'b1;
               state_in      = S_RESP;
            end else begin
               ctl.scan_next = 1'b1;
               state_in      = S_SRD;
            end
         end
         S_RESP: begin
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The scan check relies on the read address having been set in the table read state before it.
   a_schk_after_srd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCHK |-> $past(state_ff) == S_SRD)
      else $error("scan check without a preceding table read");

   // The table is written only for a write beat.
   a_we_only_write: assert property (@(posedge clock) disable iff (reset)
      ctl.ram_we |-> stat.cmd == las_pkg::CmdWrite)
      else $error("table write outside a write beat");

   // Exactly one state bit is set.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

endmodule

FILE: hdl/las_dp.sv
// Datapath of the LED animation sequencer: step table, level, position and scan logic.
// Depends on las_pkg and instantiates las_ram for the step table.
module las_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  las_pkg::dp_cmd_type                   ctl,
   output las_pkg::dp_stat_type                  stat,
   input  las_pkg::req_type                      req_data,
   input  logic                                  csr_we,
   input  logic [las_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [las_pkg::CsrDataW-1:0]          csr_wdata,
   output logic                                  rsp_valid,
   output las_pkg::rsp_type                      rsp_data
);

   localparam las_pkg::entry_type DefaultEntry = '{
      duration:  '0,
      once:      1'b0,
      target:    '0,
      rate:      '0,
      animation: las_pkg::AnimOff
   };

   // Registers.
   las_pkg::req_type                req_ff;
   logic [las_pkg::LedW-1:0]        led_id_ff, led_id_in;
   logic [las_pkg::StepCntW-1:0]    step_cnt_ff, step_cnt_in;
   logic [las_pkg::IdxW-1:0]        position_ff, position_in;
   logic [las_pkg::LevelW-1:0]      level_ff, level_in;
   logic [las_pkg::AnimW-1:0]       cur_ff, cur_in;
   logic [las_pkg::AnimW-1:0]       prev_ff, prev_in;
   logic [las_pkg::DurW-1:0]        ticks_ff, ticks_in;
   logic                            started_ff, started_in;
   logic [las_pkg::PwmW-1:0]        pwm_ff, pwm_in;
   logic                            upd_ff, upd_in;
   logic [las_pkg::CntW-1:0]        cand_ff, cand_in;
   logic [las_pkg::IdxW-1:0]        origin_ff, origin_in;
   logic [las_pkg::IdxW-1:0]        iter_ff, iter_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   las_pkg::rsp_type                rsp_ff, rsp_in;

   // Combinational helpers.
   logic [las_pkg::CntW-1:0]        count;
   logic [las_pkg::IdxW-1:0]        raddr;
   logic [las_pkg::EntryW-1:0]      ram_rdata;
   las_pkg::entry_type              rd_entry;
   las_pkg::entry_type              wr_entry;
   logic                            ram_we;
   logic                            for_this;
   logic                            pos_valid;
   las_pkg::entry_type              cur_entry;
   las_pkg::entry_type              scan_entry;
   logic [las_pkg::LevelW-1:0]      step;
   logic [las_pkg::LevelW:0]        level_sum;
   logic [las_pkg::LevelW-1:0]      tick_level;
   logic [las_pkg::AnimW-1:0]       tick_prev;
   logic [las_pkg::PwmW-1:0]        tick_pwm;
   logic                            tick_upd;
   logic [las_pkg::CntW-1:0]        cand_inc;

   // Entries in use: the step count saturated to the table depth.
   always_comb begin
      if (32'(step_cnt_ff) > las_pkg::MaxSteps) begin
         count = las_pkg::CntW'(las_pkg::MaxSteps);
      end else begin
         count = las_pkg::CntW'(step_cnt_ff);
      end
   end

   // Step table.
   always_comb begin
      case (ctl.addr_sel)
         las_pkg::ADDR_ZERO: raddr = '0;
         las_pkg::ADDR_CAND: raddr = las_pkg::IdxW'(cand_ff);
         default:            raddr = position_ff;
      endcase
   end

   assign wr_entry = '{
      duration:  req_ff.entry_duration,
      once:      req_ff.entry_once,
      target:    req_ff.entry_target,
      rate:      req_ff.entry_rate,
      animation: req_ff.entry_animation
   };
   assign ram_we = ctl.ram_we && (32'(req_ff.entry_index) < las_pkg::MaxSteps);

   las_ram #(
      .Width (las_pkg::EntryW),
      .Depth (las_pkg::MaxSteps)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (las_pkg::IdxW'(req_ff.entry_index)),
      .wdata (wr_entry),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = las_pkg::entry_type'(ram_rdata);

   // Entry qualification: an entry for another LED or beyond the count acts as off.
   assign for_this   = (rd_entry.target == led_id_ff) || (rd_entry.target == las_pkg::TargetAny);
   assign pos_valid  = las_pkg::CntW'(position_ff) < count;
   assign cur_entry  = (pos_valid && for_this) ? rd_entry : DefaultEntry;
   assign scan_entry = for_this ? rd_entry : DefaultEntry;

   // Level update for one tick.
   assign step      = las_pkg::LevelW'(1) << cur_entry.rate;
   assign level_sum = {1'b0, level_ff} + {1'b0, step};

   always_comb begin
      tick_level = level_ff;
      tick_prev  = prev_ff;
      tick_pwm   = '0;
      tick_upd   = 1'b0;
      case (cur_ff)
         las_pkg::AnimOn: begin
            if (prev_ff != las_pkg::AnimOn) begin
               if (level_ff == '0) begin
                  tick_level = las_pkg::LevelFull;
               end
               tick_pwm  = tick_level[las_pkg::LevelW-1:2];
               tick_upd  = 1'b1;
               tick_prev = las_pkg::AnimOn;
            end
         end
         las_pkg::AnimOff: begin
            if (prev_ff != las_pkg::AnimOff) begin
               tick_upd  = 1'b1;
               tick_prev = las_pkg::AnimOff;
            end
         end
         las_pkg::AnimFadeIn: begin
            if (level_sum > {1'b0, las_pkg::LevelFull}) begin
               tick_level = las_pkg::LevelFull;
            end else begin
               tick_level = level_sum[las_pkg::LevelW-1:0];
            end
            tick_pwm  = tick_level[las_pkg::LevelW-1:2];
            tick_upd  = 1'b1;
            tick_prev = las_pkg::AnimFadeIn;
         end
         default: begin
            if (level_ff < step) begin
               tick_level = '0;
            end else begin
               tick_level = level_ff - step;
            end
            tick_pwm  = tick_level[las_pkg::LevelW-1:2];
            tick_upd  = 1'b1;
            tick_prev = las_pkg::AnimFadeOut;
         end
      endcase
   end

   // Next scan candidate wraps at the count.
   assign cand_inc = ((cand_ff + las_pkg::CntW'(1)) == count) ? '0 : cand_ff + las_pkg::CntW'(1);

   // Status toward the controller.
   assign stat.cmd        = req_ff.cmd;
   assign stat.started    = started_ff;
   assign stat.ticks_le1  = ticks_ff <= las_pkg::DurW'(1);
   assign stat.count_zero = count == '0;
   assign stat.cand_ge_n  = cand_ff >= count;
   assign stat.scan_stop  = (for_this && !rd_entry.once)
                            || (las_pkg::IdxW'(cand_ff) == origin_ff)
                            || (las_pkg::CntW'(iter_ff) == count - las_pkg::CntW'(1));

   // Next-state logic of the datapath registers.
   always_comb begin
      led_id_in    = led_id_ff;
      step_cnt_in  = step_cnt_ff;
      position_in  = position_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      ticks_in     = ticks_ff;
      started_in   = started_ff;
      pwm_in       = pwm_ff;
      upd_in       = upd_ff;
      cand_in      = cand_ff;
      origin_in    = origin_ff;
      iter_in      = iter_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            las_pkg::CsrLedIdentity: led_id_in   = las_pkg::LedW'(csr_wdata);
            las_pkg::CsrStepCount:   step_cnt_in = las_pkg::StepCntW'(csr_wdata);
            default: begin
            end
         endcase
      end

      // A new beat starts with no level written.
      if (ctl.latch_req) begin
         pwm_in = '0;
         upd_in = 1'b0;
      end

      // Sequence restart at entry zero.
      if (ctl.do_start) begin
         position_in = '0;
         level_in    = '0;
         started_in  = 1'b1;
      end
      if (ctl.load_entry) begin
         cur_in   = cur_entry.animation;
         ticks_in = cur_entry.duration;
      end

      // Tick: apply the animation, then count down or advance.
      if (ctl.apply_tick) begin
         level_in = tick_level;
         prev_in  = tick_prev;
         pwm_in   = tick_pwm;
         upd_in   = tick_upd;
      end
      if (ctl.tick_dec) begin
         ticks_in = ticks_ff - las_pkg::DurW'(1);
      end
      if (ctl.adv_empty) begin
         position_in = '0;
         prev_in     = cur_ff;
         cur_in      = las_pkg::AnimOff;
         ticks_in    = '0;
      end

      // Advance scan over the table.
      if (ctl.scan_init) begin
         cand_in   = las_pkg::CntW'(position_ff) + las_pkg::CntW'(1);
         origin_in = position_ff;
         iter_in   = '0;
      end
      if (ctl.scan_norm) begin
         cand_in = cand_ff - count;
      end
      if (ctl.scan_next) begin
         cand_in = cand_inc;
         iter_in = iter_ff + las_pkg::IdxW'(1);
      end
      if (ctl.scan_done) begin
         position_in = las_pkg::IdxW'(cand_ff);
         prev_in     = cur_ff;
         cur_in      = scan_entry.animation;
         ticks_in    = scan_entry.duration;
      end

      // Result beat.
      if (ctl.respond) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{
            pwm_level:      pwm_ff,
            pwm_update:     upd_ff,
            entry_position: las_pkg::EntryIdxW'(position_ff),
            animation_now:  cur_ff
         };
      end
   end

   // Control and sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_id_ff    <= '0;
         step_cnt_ff  <= las_pkg::StepCntW'(1);
         position_ff  <= '0;
         level_ff     <= '0;
         cur_ff       <= las_pkg::AnimOff;
         prev_ff      <= las_pkg::AnimOff;
         ticks_ff     <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         led_id_ff    <= led_id_in;
         step_cnt_ff  <= step_cnt_in;
         position_ff  <= position_in;
         level_ff     <= level_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         ticks_ff     <= ticks_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         req_ff <= req_data;
      end
      pwm_ff    <= pwm_in;
      upd_ff    <= upd_in;
      cand_ff   <= cand_in;
      origin_ff <= origin_in;
      iter_ff   <= iter_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The level stays within full scale.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= las_pkg::LevelFull)
      else $error("level above full scale");

   // A result beat lasts a single cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // The scan only inspects candidates inside the count.
   a_cand_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.scan_next || ctl.scan_done) |-> cand_ff < count)
      else $error("scan candidate beyond the entries in use");

endmodule

FILE: hdl/led_animation_sequencer_unit.sv
// Top level of the LED animation sequencer: controller plus datapath.
// Depends on las_pkg, las_ctrl, las_dp and (through las_dp) las_ram.
//
// Usage:
//  - Input beats: drive req_data and raise start; a beat is taken at a rising edge
//    with start high and busy low. cmd selects tick, table write or sequence start.
//  - Result beats: exactly one per input beat, shown on rsp_data for one cycle with
//    rsp_valid high. The receiver cannot stall; results must be taken as they come.
//  - Configuration: csr_we, csr_index and csr_wdata write led_identity (index 0) or
//    step_count (index 1); write them only while the block is idle.
//  - Steps: a write, an unused command or a tick before the first start goes from
//    decode straight to the result; a start first loads entry zero. A tick applies
//    its animation and then counts down, or falls back to off at entry zero when no
//    entries are in use; otherwise the advance scan subtracts the count from the
//    candidate while it lies at or beyond the count (up to 16 times), then reads and
//    checks one table entry at a time until the scan stops.
//  - Throughput: one beat at a time; busy is high from acceptance until the result
//    is issued, and the next beat may be accepted in the cycle the result is shown.
//  - Reset: synchronous, active high; clears position, level, animations and the
//    started flag and restores the register defaults. The step table is not cleared.
module led_animation_sequencer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  las_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output las_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [las_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [las_pkg::CsrDataW-1:0]  csr_wdata
);

   las_pkg::dp_cmd_type  ctl;
   las_pkg::dp_stat_type stat;

   // Sequencing control.
   las_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   // Table, level and position datapath.
   las_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/led_level_checker.sv
// Result checker for the LED animation sequencer: predicts every result beat and compares it.
// Depends on las_pkg; instantiated beside the block by tb_led_animation_sequencer_unit.
module led_level_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  las_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  las_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [las_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [las_pkg::CsrDataW-1:0] csr_wdata,
   output int                           outstanding,
   output int                           mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the sequencer state and its two registers.
   las_pkg::entry_type            steps_mem [las_pkg::MaxSteps];
   logic [las_pkg::EntryIdxW-1:0] cur_pos;
   logic [las_pkg::LevelW-1:0]    quarters;
   logic [las_pkg::AnimW-1:0]     anim_active;
   logic [las_pkg::AnimW-1:0]     anim_shown;
   logic [las_pkg::DurW:0]        dwell;
   logic                          running;
   logic [las_pkg::LedW-1:0]      led_sel;
   logic [las_pkg::StepCntW-1:0]  step_cnt_reg;

   // Results still owed by the block, oldest first.
   las_pkg::rsp_type pending_results [$];
   int               errors_seen = 0;

   assign mismatch_count = errors_seen;

   // The count in use never exceeds the table size.
   function automatic int steps_in_use();
      return (step_cnt_reg > las_pkg::MaxSteps) ? las_pkg::MaxSteps : int'(step_cnt_reg);
   endfunction

   function automatic logic meant_for_me(las_pkg::entry_type e);
      return (e.target == led_sel) || (e.target == las_pkg::TargetAny);
   endfunction

   // Entries past the count or aimed at another LED behave as a zero-length off step.
   function automatic las_pkg::entry_type step_at(int p);
      las_pkg::entry_type dark;
      dark = '0;
      dark.animation = las_pkg::AnimOff;
      if (p >= steps_in_use()) return dark;
      if (!meant_for_me(steps_mem[p])) return dark;
      return steps_mem[p];
   endfunction

   // Scan forward cyclically for the next repeating entry of this LED; a full lap
   // without a hit lands back on the starting position.
   function automatic void move_to_next_step();
      int                 n;
      int                 p;
      int                 origin;
      las_pkg::entry_type e;
      n = steps_in_use();
      origin = cur_pos;
      p = cur_pos;
      if (n == 0) begin
         p = 0;
      end else begin
         for (int i = 0; i < n; i++) begin
            p = (p + 1) % n;
            if ((meant_for_me(steps_mem[p]) && !steps_mem[p].once) || p == origin) break;
         end
      end
      cur_pos = p[las_pkg::EntryIdxW-1:0];
      e = step_at(p);
      anim_shown = anim_active;
      anim_active = e.animation;
      dwell = {1'b0, e.duration};
   endfunction

   // Apply one accepted beat to the shadow state and return the result it must produce.
   function automatic las_pkg::rsp_type predict_beat(las_pkg::req_type b);
      las_pkg::rsp_type   r;
      las_pkg::entry_type cur;
      las_pkg::entry_type fresh;
      int                 stride;
      int                 lvl_next;
      r = '0;
      case (b.cmd)
         las_pkg::CmdWrite: begin
            fresh.animation = b.entry_animation;
            fresh.rate = b.entry_rate;
            fresh.target = b.entry_target;
            fresh.once = b.entry_once;
            fresh.duration = b.entry_duration;
            steps_mem[b.entry_index] = fresh;
         end
         las_pkg::CmdStart: begin
            cur = step_at(0);
            cur_pos = '0;
            quarters = '0;
            anim_active = cur.animation;
            dwell = {1'b0, cur.duration};
            running = 1'b1;
         end
         las_pkg::CmdTick: begin
            if (running) begin
               cur = step_at(cur_pos);
               stride = 1 << cur.rate;
               case (anim_active)
                  las_pkg::AnimOn: begin
                     // Steady on restores the kept level, or full level when none is kept.
                     if (anim_shown != las_pkg::AnimOn) begin
                        if (quarters == '0) quarters = las_pkg::LevelFull;
                        r.pwm_level = quarters[las_pkg::LevelW-1:2];
                        r.pwm_update = 1'b1;
                        anim_shown = las_pkg::AnimOn;
                     end
                  end
                  las_pkg::AnimOff: begin
                     if (anim_shown != las_pkg::AnimOff) begin
                        r.pwm_update = 1'b1;
                        anim_shown = las_pkg::AnimOff;
                     end
                  end
                  las_pkg::AnimFadeIn: begin
                     anim_shown = las_pkg::AnimFadeIn;
                     lvl_next = quarters + stride;
                     quarters = (lvl_next > las_pkg::LevelFull) ? las_pkg::LevelFull
                                                                : lvl_next[las_pkg::LevelW-1:0];
                     r.pwm_level = quarters[las_pkg::LevelW-1:2];
                     r.pwm_update = 1'b1;
                  end
                  default: begin
                     anim_shown = las_pkg::AnimFadeOut;
                     lvl_next = quarters - stride;
                     quarters = (quarters < stride) ? '0 : lvl_next[las_pkg::LevelW-1:0];
                     r.pwm_level = quarters[las_pkg::LevelW-1:2];
                     r.pwm_update = 1'b1;
                  end
               endcase
               if (dwell <= 1) move_to_next_step();
               else dwell = dwell - 1'b1;
            end
         end
         default: ;
      endcase
      r.entry_position = cur_pos;
      r.animation_now = anim_active;
      return r;
   endfunction

   // Everything is sampled at the rising edge, so the values seen are the pre-edge ones.
   always @(posedge clock) begin : watch
      las_pkg::rsp_type want;
      if (reset) begin
         pending_results.delete();
         cur_pos = '0;
         quarters = '0;
         anim_active = las_pkg::AnimOff;
         anim_shown = las_pkg::AnimOff;
         dwell = '0;
         running = 1'b0;
         led_sel = '0;
         step_cnt_reg = 5'd1;
      end else begin
         if (csr_we) begin
            if (csr_index == las_pkg::CsrLedIdentity)
               led_sel = csr_wdata[las_pkg::LedW-1:0];
            else if (csr_index == las_pkg::CsrStepCount)
               step_cnt_reg = csr_wdata[las_pkg::StepCntW-1:0];
         end

         // A result beat is settled before a new input beat can be queued behind it.
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               errors_seen++;
               if (errors_seen <= 10)
                  $display("%0t: result beat with none expected: level %0d update %0b",
                           $time, rsp_data.pwm_level, rsp_data.pwm_update);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.pwm_level !== want.pwm_level ||
                   rsp_data.pwm_update !== want.pwm_update ||
                   rsp_data.entry_position !== want.entry_position ||
                   rsp_data.animation_now !== want.animation_now) begin
                  errors_seen++;
                  // Each pair is the expected value, then the actual one.
                  if (errors_seen <= 10)
                     $display("%0t: exp/act lvl %0d/%0d upd %0b/%0b pos %0d/%0d anim %0d/%0d",
                              $time,
                              want.pwm_level, rsp_data.pwm_level,
                              want.pwm_update, rsp_data.pwm_update,
                              want.entry_position, rsp_data.entry_position,
                              want.animation_now, rsp_data.animation_now);
               end
            end
         end

         if (start && !busy) pending_results.push_back(predict_beat(req_data));
      end
      outstanding <= pending_results.size();
   end

endmodule

FILE: verif/tb_led_animation_sequencer_unit.sv
// Testbench top for led_animation_sequencer_unit: clock, reset, stimulus and the verdict.
// Depends on las_pkg, the block's RTL and led_level_checker, which does all result checking.
module tb_led_animation_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [las_pkg::CmdW-1:0] CmdUnused  = 2'd3;
   localparam int                       CycleLimit = 400000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   las_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   las_pkg::rsp_type             rsp_data;
   logic                         csr_we = 1'b0;
   logic [las_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [las_pkg::CsrDataW-1:0] csr_wdata = '0;

   int                  outstanding;
   int                  mismatch_count;
   int                  cycle_count = 0;

   // Table entries already written; nothing below the count may be read before this is set.
   logic [las_pkg::MaxSteps-1:0] written = '0;
   logic [las_pkg::LedW-1:0]     led_now = '0;
   bit                           idling = 1'b1;
   bit                           quiet = 1'b0;

   led_animation_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   led_level_checker level_watch (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   always #5 clock = ~clock;

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic las_pkg::req_type make_entry(
         input logic [las_pkg::EntryIdxW-1:0] index,
         input logic [las_pkg::AnimW-1:0] anim,
         input logic [las_pkg::RateW-1:0] rate,
         input logic [las_pkg::TargetW-1:0] target,
         input logic once,
         input logic [las_pkg::DurW-1:0] ticks);
      las_pkg::req_type b;
      b.cmd = las_pkg::CmdWrite;
      b.entry_index = index;
      b.entry_animation = anim;
      b.entry_rate = rate;
      b.entry_target = target;
      b.entry_once = once;
      b.entry_duration = ticks;
      return b;
   endfunction

   // Table write with random content, leaning toward entries this LED will actually play.
   function automatic las_pkg::req_type random_entry(input int index);
      logic [31:0]                 noise;
      logic [las_pkg::TargetW-1:0] tgt;
      logic [las_pkg::DurW-1:0]    ticks;
      int                          pick;
      noise = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 5) tgt = led_now;
      else if (pick < 7) tgt = las_pkg::TargetAny;
      else tgt = (noise[6:4] > 3'd5) ? noise[6:4] - 3'd2 : noise[6:4];
      // Mostly short steps so the sequence keeps moving; now and then a long one.
      pick = $urandom_range(0, 19);
      if (pick < 15) ticks = {13'd0, noise[10:8]};
      else if (pick < 19) ticks = {10'd0, noise[16:11]};
      else ticks = noise[31:16];
      return make_entry(index[las_pkg::EntryIdxW-1:0], noise[1:0], noise[3:2], tgt,
                        $urandom_range(0, 4) == 0, ticks);
   endfunction

   // Non-write beat; the entry fields carry junk that the block must ignore.
   function automatic las_pkg::req_type control_beat(input logic [las_pkg::CmdW-1:0] code);
      logic [31:0]      noise;
      las_pkg::req_type b;
      noise = $urandom;
      b = noise[$bits(las_pkg::req_type)-1:0];
      b.cmd = code;
      return b;
   endfunction

   // Present one input beat and return in the time step of the edge that takes it.
   task automatic issue(input las_pkg::req_type beat);
      if (!quiet) begin
         if ($urandom_range(0, 29) == 0) idling = !idling;
         if (idling && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
      if (beat.cmd == las_pkg::CmdWrite) written[beat.entry_index] = 1'b1;
      req_data <= beat;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Registers change only once every owed result has come back.
   task automatic write_register(input logic [las_pkg::CsrIdxW-1:0] index, input int value);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[las_pkg::CsrDataW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One setting of the registers followed by random traffic: restarts, runs of ticks,
   // table rewrites and the odd unused command.
   task automatic random_phase(input int led, input int count, input int items);
      int used;
      int roll;
      write_register(las_pkg::CsrLedIdentity, led);
      write_register(las_pkg::CsrStepCount, count);
      led_now = led[las_pkg::LedW-1:0];
      used = (count > las_pkg::MaxSteps) ? las_pkg::MaxSteps : count;
      for (int i = 0; i < used; i++)
         if (!written[i]) issue(random_entry(i));
      issue(control_beat(las_pkg::CmdStart));
      for (int k = 0; k < items; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)
            issue(control_beat(las_pkg::CmdTick));
         else if (roll < 80)
            issue(random_entry((used > 0 && roll < 76) ? $urandom_range(0, used - 1)
                                                       : $urandom_range(0, 15)));
         else if (roll < 90)
            issue(control_beat(las_pkg::CmdStart));
         else
            issue(control_beat(CmdUnused));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: green LED, one entry in use. Nothing may happen before a start.
      issue(control_beat(las_pkg::CmdTick));
      issue(control_beat(CmdUnused));
      issue(make_entry(4'd0, las_pkg::AnimFadeIn, 2'd3, 3'd0, 1'b0, 16'd2));
      issue(make_entry(4'd15, las_pkg::AnimFadeOut, 2'd3, las_pkg::TargetAny, 1'b1, 16'hFFFF));
      issue(control_beat(las_pkg::CmdStart));
      repeat (2) issue(control_beat(las_pkg::CmdTick));
      // A lone once entry is kept when the scan comes full circle.
      issue(make_entry(4'd0, las_pkg::AnimOn, 2'd0, las_pkg::TargetAny, 1'b1, 16'd0));
      repeat (2) issue(control_beat(las_pkg::CmdTick));
      issue(control_beat(las_pkg::CmdStart));
      repeat (2) issue(control_beat(las_pkg::CmdTick));
      // Fading in from full level must hold at the top.
      issue(make_entry(4'd0, las_pkg::AnimFadeIn, 2'd3, 3'd0, 1'b0, 16'd1));
      repeat (2) issue(control_beat(las_pkg::CmdTick));
      // An entry aimed at the red LED plays as off here.
      issue(make_entry(4'd0, las_pkg::AnimOff, 2'd1, 3'd4, 1'b0, 16'd1));
      repeat (2) issue(control_beat(las_pkg::CmdTick));
      // Fading out from zero must hold at the bottom.
      issue(make_entry(4'd0, las_pkg::AnimFadeOut, 2'd2, 3'd0, 1'b0, 16'd3));
      issue(control_beat(las_pkg::CmdStart));
      repeat (3) issue(control_beat(las_pkg::CmdTick));

      // Random traffic across several settings, extremes of both registers included.
      random_phase(4, 16, 120);
      random_phase(2, 5, 120);
      random_phase(1, 0, 60);
      random_phase(3, 31, 120);
      random_phase(0, 1, 100);
      random_phase($urandom_range(0, 4), $urandom_range(1, 16), 120);
      random_phase($urandom_range(0, 4), $urandom_range(1, 16), 120);
      // Closing stretch with the sender never pausing.
      quiet = 1'b1;
      random_phase($urandom_range(0, 4), $urandom_range(1, 16), 120);

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
